>>> rtl/matrix3_inverse_macros.svh
// Assertion macros shared by the matrix3_inverse RTL.
`ifndef MATRIX3_INVERSE_MACROS_SVH
`define MATRIX3_INVERSE_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define M3I_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication, checked out of reset.
`define M3I_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/m3i_pkg.sv
// Shared widths, cofactor index table and queue word type for the 3x3 inverse.
`default_nettype none

package m3i_pkg;

  localparam int ElemW       = 32;
  localparam int FracBits    = 16;
  localparam int NElem       = 9;
  localparam int MatN        = 3;
  localparam int ProdW       = 2 * ElemW;
  localparam int CofW        = ProdW + 1;
  localparam int MagW        = ProdW;
  localparam int DetW        = 3 * ElemW + 2;
  localparam int DmagW       = DetW - 1;
  localparam int NumW        = MagW + 2 * FracBits;
  localparam int QuoW        = ElemW;
  localparam int FrontStages = 7;
  localparam int QueueDepth  = 2;
  localparam int QPtrW       = $clog2(QueueDepth);
  localparam int QCntW       = $clog2(QueueDepth + 1);
  localparam int CofTerms    = 4;
  localparam int IdxW        = $clog2(NElem);

  localparam logic [ElemW-1:0] SatPos = {1'b0, {(ElemW-1){1'b1}}};
  localparam logic [ElemW-1:0] SatNeg = {1'b1, {(ElemW-1){1'b0}}};

  // adjugate entry k = a[p]*a[q] - a[r]*a[s], sign already folded in
  localparam logic [IdxW-1:0] CofIdx [NElem][CofTerms] = '{
    '{IdxW'(4), IdxW'(8), IdxW'(5), IdxW'(7)},
    '{IdxW'(2), IdxW'(7), IdxW'(1), IdxW'(8)},
    '{IdxW'(1), IdxW'(5), IdxW'(2), IdxW'(4)},
    '{IdxW'(5), IdxW'(6), IdxW'(3), IdxW'(8)},
    '{IdxW'(0), IdxW'(8), IdxW'(2), IdxW'(6)},
    '{IdxW'(2), IdxW'(3), IdxW'(0), IdxW'(5)},
    '{IdxW'(3), IdxW'(7), IdxW'(4), IdxW'(6)},
    '{IdxW'(1), IdxW'(6), IdxW'(0), IdxW'(7)},
    '{IdxW'(0), IdxW'(4), IdxW'(1), IdxW'(3)}
  };

  // one classified matrix handed from the front end to the divider array
  typedef struct packed {
    logic [NElem-1:0][MagW-1:0] num_mag;
    logic [NElem-1:0]           neg;
    logic [DmagW-1:0]           den;
    logic                       singular;
  } m3i_word_t;

endpackage

`default_nettype wire

>>> rtl/matrix3_inverse.sv
// Top level of the 3x3 fixed-point matrix inverse by the adjugate.
//
// Usage: drive the nine Q16.16 elements on in_rXcY_i and raise start_i; the
// word is taken at a rising edge where start_i is high and busy_o is low.
// One matrix can be taken every cycle. Each word yields one result: done_o
// is high for exactly one cycle with inv_rXcY_o and singular_o valid, and
// that result is taken at the edge ending that cycle.
// From the accepting edge to the edge that takes the result, a word passes
// 7 front stages (products, cofactors, determinant, classify), one queue
// slot, one divider load stage, 32 divider stages (one quotient bit each,
// set by the restoring compare/subtract over the 97-bit determinant
// magnitude), and the output register. Throughput is one matrix per cycle.
// busy_o only rises if the two-word queue fills, which the divider, draining
// every cycle, never lets happen. singular_o marks a zero determinant; the
// elements are then zero. Reset empties the pipeline and queue; no result
// leaves until a new word is taken. The receiver cannot stall.
`default_nettype none

module matrix3_inverse (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] in_r0c0_i,
  input  logic [31:0] in_r0c1_i,
  input  logic [31:0] in_r0c2_i,
  input  logic [31:0] in_r1c0_i,
  input  logic [31:0] in_r1c1_i,
  input  logic [31:0] in_r1c2_i,
  input  logic [31:0] in_r2c0_i,
  input  logic [31:0] in_r2c1_i,
  input  logic [31:0] in_r2c2_i,
  output logic        done_o,
  output logic [31:0] inv_r0c0_o,
  output logic [31:0] inv_r0c1_o,
  output logic [31:0] inv_r0c2_o,
  output logic [31:0] inv_r1c0_o,
  output logic [31:0] inv_r1c1_o,
  output logic [31:0] inv_r1c2_o,
  output logic [31:0] inv_r2c0_o,
  output logic [31:0] inv_r2c1_o,
  output logic [31:0] inv_r2c2_o,
  output logic        singular_o
);
  import m3i_pkg::*;

  logic [NElem-1:0][ElemW-1:0] elem;
  logic [NElem-1:0][ElemW-1:0] inv;
  logic                        accept;
  logic                        front_vld;
  m3i_word_t                   front_word;
  logic                        q_vld;
  m3i_word_t                   q_word;
  logic                        q_full;

  assign accept = start_i & ~q_full;
  assign busy_o = q_full;

  // row-major element bundle
  assign elem = {in_r2c2_i, in_r2c1_i, in_r2c0_i,
                 in_r1c2_i, in_r1c1_i, in_r1c0_i,
                 in_r0c2_i, in_r0c1_i, in_r0c0_i};

  m3i_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .elem_i  (elem),
    .valid_o (front_vld),
    .word_o  (front_word)
  );

  m3i_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_vld),
    .word_i  (front_word),
    .valid_o (q_vld),
    .word_o  (q_word),
    .full_o  (q_full)
  );

  m3i_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (q_vld),
    .word_i     (q_word),
    .valid_o    (done_o),
    .inv_o      (inv),
    .singular_o (singular_o)
  );

  assign inv_r0c0_o = inv[0];
  assign inv_r0c1_o = inv[1];
  assign inv_r0c2_o = inv[2];
  assign inv_r1c0_o = inv[3];
  assign inv_r1c1_o = inv[4];
  assign inv_r1c2_o = inv[5];
  assign inv_r2c0_o = inv[6];
  assign inv_r2c1_o = inv[7];
  assign inv_r2c2_o = inv[8];

endmodule

`default_nettype wire

>>> rtl/m3i_front.sv
// Front end: cofactors, determinant and sign/zero classification, 7 stages.
`default_nettype none

module m3i_front (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       start_i,
  input  logic [m3i_pkg::NElem-1:0][m3i_pkg::ElemW-1:0] elem_i,
  output logic                                       valid_o,
  output m3i_pkg::m3i_word_t                         word_o
);
  import m3i_pkg::*;

  logic [FrontStages-1:0] vld_q, vld_d;

  logic signed [ElemW-1:0] a1_q   [NElem];
  logic signed [ElemW-1:0] a1_d   [NElem];
  logic signed [ProdW-1:0] pa2_q  [NElem];
  logic signed [ProdW-1:0] pa2_d  [NElem];
  logic signed [ProdW-1:0] pb2_q  [NElem];
  logic signed [ProdW-1:0] pb2_d  [NElem];
  logic signed [ElemW-1:0] r2_q   [MatN];
  logic signed [ElemW-1:0] r2_d   [MatN];
  logic signed [ElemW-1:0] r3_q   [MatN];
  logic signed [ElemW-1:0] r3_d   [MatN];
  logic signed [CofW-1:0]  cof3_q [NElem];
  logic signed [CofW-1:0]  cof3_d [NElem];
  logic signed [CofW-1:0]  cof4_q [NElem];
  logic signed [CofW-1:0]  cof4_d [NElem];
  logic signed [CofW-1:0]  cof5_q [NElem];
  logic signed [CofW-1:0]  cof5_d [NElem];
  logic signed [CofW-1:0]  tlo4_q [MatN];
  logic signed [CofW-1:0]  tlo4_d [MatN];
  logic signed [CofW-1:0]  thi4_q [MatN];
  logic signed [CofW-1:0]  thi4_d [MatN];
  logic signed [DetW-1:0]  term5_q[MatN];
  logic signed [DetW-1:0]  term5_d[MatN];
  logic signed [DetW-1:0]  det6_q, det6_d;
  logic [MagW-1:0]         mag6_q [NElem];
  logic [MagW-1:0]         mag6_d [NElem];
  logic [NElem-1:0]        cneg6_q, cneg6_d;
  m3i_word_t               word_q, word_d;

  // valid shift line
  assign vld_d = {vld_q[FrontStages-2:0], start_i};

  // datapath: products, cofactors, split products, determinant, classify
  always_comb begin
    logic det_neg;
    for (int k = 0; k < NElem; k++) begin
      a1_d[k]   = elem_i[k];
      pa2_d[k]  = a1_q[CofIdx[k][0]] * a1_q[CofIdx[k][1]];
      pb2_d[k]  = a1_q[CofIdx[k][2]] * a1_q[CofIdx[k][3]];
      cof3_d[k] = CofW'(pa2_q[k]) - CofW'(pb2_q[k]);
      cof4_d[k] = cof3_q[k];
      cof5_d[k] = cof4_q[k];
      cneg6_d[k] = cof5_q[k][CofW-1];
      mag6_d[k]  = cof5_q[k][CofW-1] ? MagW'(-cof5_q[k]) : MagW'(cof5_q[k]);
    end
    // det expanded along row 0: cofactors of row 0 sit at adjugate column 0
    det6_d = '0;
    for (int j = 0; j < MatN; j++) begin
      r2_d[j]    = a1_q[j];
      r3_d[j]    = r2_q[j];
      tlo4_d[j]  = r3_q[j] * $signed({1'b0, cof3_q[MatN*j][ElemW-1:0]});
      thi4_d[j]  = r3_q[j] * $signed(cof3_q[MatN*j][CofW-1:ElemW]);
      term5_d[j] = (DetW'(thi4_q[j]) <<< ElemW) + DetW'(tlo4_q[j]);
      det6_d     = det6_d + term5_q[j];
    end
    det_neg         = det6_q[DetW-1];
    word_d.den      = DmagW'(det_neg ? -det6_q : det6_q);
    word_d.singular = (det6_q == '0);
    for (int k = 0; k < NElem; k++) begin
      word_d.num_mag[k] = mag6_q[k];
      word_d.neg[k]     = cneg6_q[k] ^ det_neg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q    <= a1_d;
    pa2_q   <= pa2_d;
    pb2_q   <= pb2_d;
    r2_q    <= r2_d;
    r3_q    <= r3_d;
    cof3_q  <= cof3_d;
    cof4_q  <= cof4_d;
    cof5_q  <= cof5_d;
    tlo4_q  <= tlo4_d;
    thi4_q  <= thi4_d;
    term5_q <= term5_d;
    det6_q  <= det6_d;
    mag6_q  <= mag6_d;
    cneg6_q <= cneg6_d;
    word_q  <= word_d;
  end

  assign valid_o = vld_q[FrontStages-1];
  assign word_o  = word_q;

endmodule

`default_nettype wire

>>> rtl/m3i_queue.sv
// Two-word queue between the front end and the divider array.
`default_nettype none
`include "matrix3_inverse_macros.svh"

module m3i_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  m3i_pkg::m3i_word_t word_i,
  output logic               valid_o,
  output m3i_pkg::m3i_word_t word_o,
  output logic               full_o
);
  import m3i_pkg::*;

  m3i_word_t        mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             pop;

  // back end takes a word whenever one is there
  assign pop     = (count_q != '0);
  assign valid_o = pop;
  assign word_o  = mem_q[rd_q];
  assign full_o  = (count_q == QCntW'(QueueDepth));

  always_comb begin
    wr_d    = push_i ? wr_q + 1'b1 : wr_q;
    rd_d    = pop ? rd_q + 1'b1 : rd_q;
    count_d = count_q + QCntW'(push_i) - QCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= word_i;
    end
  end

  // the divider drains every cycle, so the queue never backs up
  `M3I_ASSERT(a_queue_shallow, count_q <= QCntW'(1), "queue holds more than one word")
  `M3I_ASSERT_IMPL(a_no_push_full, push_i, !full_o, "push into a full queue")

endmodule

`default_nettype wire

>>> rtl/m3i_div.sv
// Back end: nine pipelined restoring dividers, one quotient bit per stage, saturation.
`default_nettype none
`include "matrix3_inverse_macros.svh"

module m3i_div (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       valid_i,
  input  m3i_pkg::m3i_word_t                         word_i,
  output logic                                       valid_o,
  output logic [m3i_pkg::NElem-1:0][m3i_pkg::ElemW-1:0] inv_o,
  output logic                                       singular_o
);
  import m3i_pkg::*;

  localparam int NStage = QuoW;
  localparam int CmpW   = DmagW + QuoW;

  logic [NStage:0]      sv_q, sv_d;
  logic [NStage:0]      sing_q, sing_d;
  logic [NumW-1:0]      rem_q [NStage+1][NElem];
  logic [NumW-1:0]      rem_d [NStage+1][NElem];
  logic [QuoW-1:0]      quo_q [NStage+1][NElem];
  logic [QuoW-1:0]      quo_d [NStage+1][NElem];
  logic [NElem-1:0]     ovf_q [NStage+1];
  logic [NElem-1:0]     ovf_d [NStage+1];
  logic [NElem-1:0]     neg_q [NStage+1];
  logic [NElem-1:0]     neg_d [NStage+1];
  logic [DmagW-1:0]     den_q [NStage+1];
  logic [DmagW-1:0]     den_d [NStage+1];
  logic                 out_vld_q;
  logic [NElem-1:0][ElemW-1:0] inv_q, inv_d;
  logic                 out_sing_q;

  // stage 0 loads the word, stage s settles quotient bit QuoW-s
  always_comb begin
    logic [CmpW-1:0] sh;
    logic            ge;
    logic [QuoW-1:0] q;
    sv_d[0]   = valid_i;
    sing_d[0] = word_i.singular;
    den_d[0]  = word_i.den;
    neg_d[0]  = word_i.neg;
    for (int k = 0; k < NElem; k++) begin
      rem_d[0][k] = NumW'(word_i.num_mag[k]) << (2 * FracBits);
      quo_d[0][k] = '0;
      // quotient would need more than QuoW bits
      ovf_d[0][k] = (CmpW'(NumW'(word_i.num_mag[k]) << (2 * FracBits)))
                    >= (CmpW'(word_i.den) << QuoW);
    end
    for (int s = 1; s <= NStage; s++) begin
      sv_d[s]   = sv_q[s-1];
      sing_d[s] = sing_q[s-1];
      den_d[s]  = den_q[s-1];
      neg_d[s]  = neg_q[s-1];
      ovf_d[s]  = ovf_q[s-1];
      sh        = CmpW'(den_q[s-1]) << (QuoW - s);
      for (int k = 0; k < NElem; k++) begin
        ge          = CmpW'(rem_q[s-1][k]) >= sh;
        rem_d[s][k] = ge ? rem_q[s-1][k] - NumW'(sh) : rem_q[s-1][k];
        quo_d[s][k] = quo_q[s-1][k] | (ge ? (QuoW'(1) << (QuoW - s)) : '0);
      end
    end
    // sign, saturation, singular override
    for (int k = 0; k < NElem; k++) begin
      q = quo_q[NStage][k];
      if (sing_q[NStage]) begin
        inv_d[k] = '0;
      end else if (neg_q[NStage][k]) begin
        inv_d[k] = (ovf_q[NStage][k] || (q[QuoW-1] && (q[QuoW-2:0] != '0)))
                   ? SatNeg : ElemW'(-q);
      end else begin
        inv_d[k] = (ovf_q[NStage][k] || q[QuoW-1]) ? SatPos : ElemW'(q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      sv_q      <= sv_d;
      out_vld_q <= sv_q[NStage];
    end
  end

  always_ff @(posedge clk_i) begin
    sing_q     <= sing_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    ovf_q      <= ovf_d;
    neg_q      <= neg_d;
    den_q      <= den_d;
    inv_q      <= inv_d;
    out_sing_q <= sing_q[NStage];
  end

  assign valid_o    = out_vld_q;
  assign inv_o      = inv_q;
  assign singular_o = out_sing_q;

  `M3I_ASSERT_IMPL(a_singular_zero, valid_o && singular_o, inv_o == '0,
                   "singular result with nonzero elements")

endmodule

`default_nettype wire
